// ===== src/mmcr_pkg.sv =====
package mmcr_pkg;

  // Filter geometry.
  localparam int TAPS      = 8;
  localparam int PHASES    = 64;
  localparam int NPROTO    = TAPS * PHASES;
  localparam int NPROTO_M1 = NPROTO - 1;
  localparam int PH_W      = $clog2(PHASES);
  localparam int K_W       = $clog2(TAPS);
  localparam int KC_W      = $clog2(TAPS + 1);
  localparam int ROM_AW    = $clog2(NPROTO);
  localparam int ACC_W     = 32 + K_W + 1;

  // Sample queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // Loop arithmetic.
  localparam int ERR_W   = 17;
  localparam int MAX_RUN = 4;
  localparam int RUN_W   = 2;

  // Register reset values.
  localparam logic        RST_COMPLEX_MODE = 1'b1;
  localparam logic [23:0] RST_NOMINAL      = 24'd131072;
  localparam logic [15:0] RST_INIT_MU      = 16'd32768;
  localparam logic [15:0] RST_FREQ_GAIN    = 16'd16;
  localparam logic [15:0] RST_MU_GAIN      = 16'd3277;
  localparam logic [15:0] RST_REL_LIMIT    = 16'd328;

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_COMPLEX_MODE  = 3'd0,
    REG_NOMINAL_OMEGA = 3'd1,
    REG_INITIAL_MU    = 3'd2,
    REG_FREQ_GAIN     = 3'd3,
    REG_MU_GAIN       = 3'd4,
    REG_REL_LIMIT     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } sample_t;

  typedef struct packed {
    logic        complex_mode;
    logic [23:0] nominal_omega;
    logic [15:0] initial_mu;
    logic [15:0] freq_gain;
    logic [15:0] mu_gain;
    logic [15:0] omega_rel_limit;
    logic        load_omega;
    logic        load_mu;
  } mmcr_cfg_t;

  typedef struct packed {
    logic [QC_W-1:0] count;
  } front_stat_t;

  typedef struct packed {
    logic             busy;
    logic [RUN_W-1:0] run_cnt;
  } back_stat_t;

  typedef logic signed [15:0] tap_rom_t [NPROTO];

  localparam longint Q30 = 64'sd1073741824;

  // sin(2*pi*a / 2^32) in Q30, fifth-order integer approximation.
  function automatic longint isin(logic [31:0] a);
    longint x;
    longint x2;
    longint t;
    longint y;
    x = longint'(a[29:0]);
    if (a[30]) x = Q30 - x;
    x2 = (x * x) >>> 30;
    t  = 64'sd688904926 - ((x2 * 64'sd76016958) >>> 30);
    t  = 64'sd1686629713 - ((x2 * t) >>> 30);
    y  = (x * t) >>> 30;
    return a[31] ? -y : y;
  endfunction

  // Quotient truncated towards zero, by long division (elaboration only).
  function automatic longint sdiv_trunc(longint num, longint den);
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    longint unsigned r;
    logic neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? longint'(-num) : num;
    ud  = (den < 0) ? longint'(-den) : den;
    q   = '0;
    r   = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], un[i]};
      if (r >= ud) begin
        r    = r - ud;
        q[i] = 1'b1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Windowed sinc prototype, stored as entry phase*TAPS + tap.
  function automatic tap_rom_t build_tap_rom();
    tap_rom_t rom;
    longint d;
    longint ad;
    longint s;
    longint w;
    longint v;
    longint unsigned thw;
    logic [31:0] ang;
    logic [31:0] th;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
    for (int n = 0; n < NPROTO; n++) begin
      d  = 2 * longint'(n) - longint'(NPROTO_M1);
      ad = (d < 0) ? -d : d;
      if (ad == 0) begin
        s = Q30;
      end else begin
        ang = 32'((ad << 30) / PHASES);
        s   = (isin(ang) * 64'sd341782638 + (64'sd1 <<< 29)) >>> 30;
        s   = sdiv_trunc(s * 2 * PHASES, ad);
      end
      thw = (longint'(n) << 32) / NPROTO_M1;
      th  = thw[31:0];
      a1  = th + 32'h4000_0000;
      a2  = (th << 1) + 32'h4000_0000;
      a3  = (th * 32'd3) + 32'h4000_0000;
      w = 64'sd382002981 * Q30 - 64'sd523337470 * isin(a1)
          + 64'sd154867931 * isin(a2) - 64'sd13533442 * isin(a3);
      w = (w + (64'sd1 <<< 29)) >>> 30;
      v = (s * w + (64'sd1 <<< 44)) >>> 45;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      rom[(PHASES - 1 - (n % PHASES)) * TAPS + n / PHASES] = 16'(v);
    end
    return rom;
  endfunction

endpackage

// ===== src/mmcr_front.sv =====
module mmcr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 complex_mode_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mmcr_pkg::sample_t    in_sample_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output mmcr_pkg::sample_t    q_sample_o,
  output mmcr_pkg::front_stat_t stat_o
);
  import mmcr_pkg::*;

  sample_t         mem_q [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] count_q;
  logic            push, pop;
  sample_t         entry;

  assign in_ready_o = (count_q < QC_W'(Q_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (count_q != '0);
  assign q_valid_o  = (count_q != '0);
  assign q_sample_o = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;

  // In real mode the imaginary part is stored as zero.
  always_comb begin
    entry    = in_sample_i;
    entry.im = complex_mode_i ? in_sample_i.im : '0;
  end

  // Sample storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= entry;
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_q <= count_q + QC_W'(push) - QC_W'(pop);
    end
  end

endmodule

// ===== src/mmcr_back.sv =====
module mmcr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mmcr_pkg::mmcr_cfg_t   cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  mmcr_pkg::sample_t     q_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mmcr_pkg::sample_t     out_sample_o,
  output logic                  out_last_o,
  output mmcr_pkg::back_stat_t  stat_o
);
  import mmcr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PHASE, ST_MAC, ST_ROUND, ST_ERR, ST_MUL, ST_OMEGA, ST_MU, ST_EMIT
  } state_e;

  localparam tap_rom_t TAP_ROM = build_tap_rom();

  state_e               state_q;
  sample_t              line_q [TAPS];
  logic [15:0]          mu_q;
  logic [23:0]          omega_q;
  logic [7:0]           skip_q;
  logic signed [15:0]   prev_real_q;
  sample_t              prev1_q, prev2_q;
  logic [3:0]           slice_q;
  logic [PH_W-1:0]      p_q;
  logic [KC_W-1:0]      k_q;
  logic signed [15:0]   rom_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [15:0]   ore_q, oim_q;
  logic signed [ERR_W:0] err_q;
  logic signed [34:0]   prod_om_q, prod_mu_q;
  logic [39:0]          prod_lim_q;
  logic signed [17:0]   inc_mu_q;
  logic [RUN_W-1:0]     run_q;
  logic                 last_q;
  logic [7:0]           skip_new_q;
  logic                 out_valid_q;
  sample_t              out_q;
  logic                 out_last_q;

  // Combinational helpers.
  logic [16+PH_W:0]        p_full;
  logic [K_W-1:0]          km1;
  logic [ROM_AW-1:0]       rom_addr;
  logic signed [31:0]      mul_re, mul_im;
  logic signed [ACC_W-1:0] rs_re, rs_im;
  logic signed [15:0]      sat_re, sat_im;
  logic signed [20:0]      err_raw;
  logic signed [ERR_W:0]   err_clip;
  logic                    c0r, c0i;
  logic signed [35:0]      inc_om, om, diff, lim, nom;
  logic [23:0]             om_sat;
  logic signed [27:0]      macc;
  logic signed [11:0]      adv;
  logic                    out_free;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;
  assign out_last_o   = out_last_q;
  assign out_free     = !out_valid_q || out_ready_i;
  assign q_pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign stat_o.busy    = (state_q != ST_IDLE);
  assign stat_o.run_cnt = run_q;

  // Phase pick: round(mu * PHASES), clamped to the last sub-filter.
  assign p_full = ({{(PH_W+1){1'b0}}, mu_q} * (17+PH_W)'(PHASES)) + (17+PH_W)'(32768);

  assign km1      = K_W'(k_q - 1'b1);
  assign rom_addr = ROM_AW'(p_q * TAPS) + ROM_AW'(k_q[K_W-1:0]);

  // Full-width tap products for the shared complex MAC.
  assign mul_re = line_q[km1].re * rom_q;
  assign mul_im = line_q[km1].im * rom_q;

  // Rounding and saturation of the filter sums.
  always_comb begin
    rs_re = (acc_re_q + ACC_W'(16384)) >>> 15;
    rs_im = (acc_im_q + ACC_W'(16384)) >>> 15;
    sat_re = (rs_re > 32767) ? 16'sh7FFF : (rs_re < -32768) ? -16'sh8000 : 16'(rs_re);
    sat_im = (rs_im > 32767) ? 16'sh7FFF : (rs_im < -32768) ? -16'sh8000 : 16'(rs_im);
  end

  // Timing error detector.
  always_comb begin
    c0r = (ore_q > 0);
    c0i = (oim_q > 0);
    if (!cfg_i.complex_mode) begin
      err_raw = ((prev_real_q < 0) ? -21'(ore_q) : 21'(ore_q))
              - ((ore_q < 0) ? -21'(prev_real_q) : 21'(prev_real_q));
    end else begin
      err_raw = (slice_q[0] ? 21'(ore_q) - 21'(prev2_q.re) : 21'sd0)
              + (slice_q[1] ? 21'(oim_q) - 21'(prev2_q.im) : 21'sd0);
      if (c0r && !slice_q[2]) err_raw = err_raw - 21'(prev1_q.re);
      if (!c0r && slice_q[2]) err_raw = err_raw + 21'(prev1_q.re);
      if (c0i && !slice_q[3]) err_raw = err_raw - 21'(prev1_q.im);
      if (!c0i && slice_q[3]) err_raw = err_raw + 21'(prev1_q.im);
    end
    if (err_raw > 32768)       err_clip = 18'sd32768;
    else if (err_raw < -32768) err_clip = -18'sd32768;
    else                       err_clip = 18'(err_raw);
  end

  // Omega update, held within the limit around nominal.
  always_comb begin
    inc_om = 36'((prod_om_q + 35'sd16384) >>> 15);
    lim    = $signed({12'd0, 24'((prod_lim_q + 40'd32768) >> 16)});
    nom    = $signed({12'd0, cfg_i.nominal_omega});
    om     = $signed({12'd0, omega_q}) + inc_om;
    diff   = om - nom;
    if (diff > lim)  diff = lim;
    if (diff < -lim) diff = -lim;
    om = nom + diff;
    if (om < 0)               om_sat = '0;
    else if (om > 36'hFFFFFF) om_sat = 24'hFFFFFF;
    else                      om_sat = om[23:0];
  end

  // Phase accumulator and advance.
  assign macc = $signed({12'd0, mu_q}) + $signed({4'd0, omega_q}) + 28'(inc_mu_q);
  assign adv  = macc[27:16];

  // Filter taps, read one per cycle.
  always_ff @(posedge clk_i) begin
    rom_q <= TAP_ROM[rom_addr];
  end

  // Sequencer and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < TAPS; i++) line_q[i] <= '0;
      mu_q        <= RST_INIT_MU;
      omega_q     <= RST_NOMINAL;
      skip_q      <= '0;
      prev_real_q <= '0;
      prev1_q     <= '0;
      prev2_q     <= '0;
      slice_q     <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      k_q         <= '0;
    end else begin
      // A taken beat empties the output register unless a new one is loaded.
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) out_valid_q <= 1'b0;
      if (cfg_i.load_omega) omega_q <= cfg_i.nominal_omega;
      if (cfg_i.load_mu)    mu_q    <= cfg_i.initial_mu;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            for (int i = 0; i < TAPS - 1; i++) line_q[i] <= line_q[i+1];
            line_q[TAPS-1] <= q_sample_i;
            if (skip_q != '0) skip_q <= skip_q - 1'b1;
            else              state_q <= ST_PHASE;
          end
        end
        ST_PHASE: begin
          p_q <= (p_full[16+PH_W:16] > (PH_W+1)'(PHASES - 1)) ? PH_W'(PHASES - 1)
                                                              : p_full[15+PH_W:16];
          k_q      <= '0;
          acc_re_q <= '0;
          acc_im_q <= '0;
          state_q  <= ST_MAC;
        end
        ST_MAC: begin
          if (k_q != '0) begin
            acc_re_q <= acc_re_q + ACC_W'(mul_re);
            acc_im_q <= acc_im_q + ACC_W'(mul_im);
          end
          if (k_q == KC_W'(TAPS)) state_q <= ST_ROUND;
          else                    k_q <= k_q + 1'b1;
        end
        ST_ROUND: begin
          ore_q   <= sat_re;
          oim_q   <= cfg_i.complex_mode ? sat_im : '0;
          state_q <= ST_ERR;
        end
        ST_ERR: begin
          err_q <= err_clip;
          if (!cfg_i.complex_mode) begin
            prev_real_q <= ore_q;
          end else begin
            prev2_q <= prev1_q;
            prev1_q <= '{im: oim_q, re: ore_q};
            slice_q <= {slice_q[1:0], c0i, c0r};
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_om_q  <= $signed({1'b0, cfg_i.freq_gain}) * err_q;
          prod_mu_q  <= $signed({1'b0, cfg_i.mu_gain}) * err_q;
          prod_lim_q <= cfg_i.omega_rel_limit * cfg_i.nominal_omega;
          state_q    <= ST_OMEGA;
        end
        ST_OMEGA: begin
          omega_q  <= om_sat;
          inc_mu_q <= 18'((prod_mu_q + 35'sd16384) >>> 15);
          state_q  <= ST_MU;
        end
        ST_MU: begin
          mu_q <= macc[15:0];
          if (adv <= 0) begin
            last_q     <= (run_q == RUN_W'(MAX_RUN - 1));
            skip_new_q <= '0;
          end else begin
            last_q     <= 1'b1;
            skip_new_q <= (adv > 256) ? 8'd255 : 8'(adv - 1);
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= '{im: oim_q, re: ore_q};
            out_last_q  <= last_q;
            if (last_q) begin
              skip_q  <= skip_new_q;
              run_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              run_q   <= run_q + 1'b1;
              state_q <= ST_PHASE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/mm_clock_recovery.sv =====
// Channel   | Dir | Contents
// s_axis    | in  | tdata: in_re [15:0], in_im [31:16]
// m_axis    | out | tdata: out_re [15:0], out_im [31:16]; tlast: run_last
// apb       | in  | six registers at byte addresses 0x00 to 0x14
//
// The first output symbol of a sample is loaded into the output register after
// the queue pop, the phase pick, the shared complex MAC over the 8 taps and the
// rounding, error, gain product, omega, mu and output load steps. Each further
// symbol of the same run repeats from the phase pick. A sample that only moves
// the delay line is taken in the idle state. A two-beat queue takes input beats
// while the sequencer works or waits on a stalled output. Reset is asynchronous
// and loads the register defaults.
module mm_clock_recovery
  import mmcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // in_re [15:0], in_im [31:16]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,  // out_re [15:0], out_im [31:16]
  output logic                 m_axis_tlast,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  mmcr_cfg_t   cfg;
  front_stat_t fstat;
  back_stat_t  bstat;
  logic        cm_q;
  logic [23:0] nom_q;
  logic [15:0] imu_q, og_q, mg_q, rl_q;
  logic        ld_om_q, ld_mu_q;
  logic        wr_en;
  reg_idx_e    widx;
  logic        q_valid, q_pop;
  sample_t     q_sample, out_sample;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign widx   = reg_idx_e'(paddr[4:2]);

  // Register writes; omega and mu loads follow in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q    <= RST_COMPLEX_MODE;
      nom_q   <= RST_NOMINAL;
      imu_q   <= RST_INIT_MU;
      og_q    <= RST_FREQ_GAIN;
      mg_q    <= RST_MU_GAIN;
      rl_q    <= RST_REL_LIMIT;
      ld_om_q <= 1'b0;
      ld_mu_q <= 1'b0;
    end else begin
      ld_om_q <= 1'b0;
      ld_mu_q <= 1'b0;
      if (wr_en && paddr[1:0] == 2'b00) begin
        case (widx)
          REG_COMPLEX_MODE:  cm_q <= pwdata[0];
          REG_NOMINAL_OMEGA: begin
            nom_q   <= pwdata[23:0];
            ld_om_q <= 1'b1;
          end
          REG_INITIAL_MU: begin
            imu_q   <= pwdata[15:0];
            ld_mu_q <= 1'b1;
          end
          REG_FREQ_GAIN:     og_q <= pwdata[15:0];
          REG_MU_GAIN:       mg_q <= pwdata[15:0];
          REG_REL_LIMIT:     rl_q <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Register read-back.
  always_comb begin
    case (widx)
      REG_COMPLEX_MODE:  prdata = {31'd0, cm_q};
      REG_NOMINAL_OMEGA: prdata = {8'd0, nom_q};
      REG_INITIAL_MU:    prdata = {16'd0, imu_q};
      REG_FREQ_GAIN:     prdata = {16'd0, og_q};
      REG_MU_GAIN:       prdata = {16'd0, mg_q};
      REG_REL_LIMIT:     prdata = {16'd0, rl_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{complex_mode: cm_q, nominal_omega: nom_q, initial_mu: imu_q,
                 freq_gain: og_q, mu_gain: mg_q, omega_rel_limit: rl_q,
                 load_omega: ld_om_q, load_mu: ld_mu_q};

  mmcr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .complex_mode_i (cm_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_sample_i    (sample_t'(s_axis_tdata)),
    .q_valid_o      (q_valid),
    .q_pop_i        (q_pop),
    .q_sample_o     (q_sample),
    .stat_o         (fstat)
  );

  mmcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_sample_i   (q_sample),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_last_o   (m_axis_tlast),
    .stat_o       (bstat)
  );

  assign m_axis_tdata = out_sample;

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= QC_W'(Q_DEPTH))
    else $error("sample queue overfilled");

  // Input is refused exactly when the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (fstat.count != QC_W'(Q_DEPTH)))
    else $error("input ready disagrees with queue level");

  // A finished run leaves the sequencer idle with the run count cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bstat.busy |-> bstat.run_cnt == '0)
    else $error("run count left set while idle");

endmodule
